>>> rtl/qcf_pkg.sv
// Shared types and constants of the q-gram count filter.
// No dependencies; imported by every module of the block.
package qcf_pkg;

    localparam int RECORDS      = 4096;
    localparam int REC_W        = 12;
    localparam int WORD_W       = 6;
    localparam int BIT_W        = 6;
    localparam int GRAM_COUNT   = 1000;
    localparam int GRAM_W       = 10;
    localparam int POSTINGS_DEF = 65536;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [7:0] THRESH_RESET = 8'd4;
    localparam logic [7:0] COUNT_MAX    = 8'd255;
    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] CHAR_J       = 8'h4A;
    localparam logic [3:0] NOT_LETTER   = 4'hF;
    localparam logic [3:0] LETTER_LIMIT = 4'd10;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_END   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ORDER = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_WALK = 2'd1,
        CMD_END  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [GRAM_W-1:0]  gram;
        logic [REC_W-1:0]   rid;
    } cmd_t;

endpackage

>>> rtl/qcf_front.sv
// Front end: accepts input words, tracks the query window, issues commands.
// Depends on qcf_pkg.
module qcf_front
    import qcf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        mode,
    input  logic [GRAM_W-1:0] gram_code,
    input  logic [REC_W-1:0]  record_id,
    input  logic [7:0]        query_char,
    input  logic              q_full,
    input  logic              clearing,
    output logic              push,
    output cmd_t              push_cmd
);

    logic [7:0] window_reg, window_next;
    logic [1:0] fill_reg, fill_next;
    logic       accept;
    logic [3:0] d, a, b;

    assign in_stall = q_full | clearing;
    assign accept   = in_valid & ~in_stall;
    assign a        = window_reg[7:4];
    assign b        = window_reg[3:0];
    assign d        = (query_char >= CHAR_A && query_char <= CHAR_J) ?
                      4'(query_char - CHAR_A) : NOT_LETTER;

    always_comb
    begin
        window_next   = window_reg;
        fill_next     = fill_reg;
        push          = 1'b0;
        push_cmd.kind = CMD_LOAD;
        push_cmd.gram = gram_code;
        push_cmd.rid  = record_id;
        if (accept)
        begin
            unique case (mode)
                MODE_LOAD:
                begin
                    push = 1'b1;
                end
                MODE_QUERY:
                begin
                    push_cmd.kind = CMD_WALK;
                    push_cmd.gram = GRAM_W'(a) * GRAM_W'(100) + GRAM_W'(b) * GRAM_W'(10)
                                    + GRAM_W'(d);
                    push = (fill_reg == 2'd2) && (a < LETTER_LIMIT) && (b < LETTER_LIMIT)
                           && (d < LETTER_LIMIT);
                    window_next = {window_reg[3:0], d};
                    if (fill_reg != 2'd2)
                        fill_next = fill_reg + 2'd1;
                end
                MODE_END:
                begin
                    push_cmd.kind = CMD_END;
                    push          = 1'b1;
                    window_next   = '0;
                    fill_next     = '0;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

>>> rtl/qcf_queue.sv
// Command queue between front and back end.
// Depends on qcf_pkg.
module qcf_queue
    import qcf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output cmd_t q_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [PTR_W:0]   cnt_reg;

    assign full    = (cnt_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = slots[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
    end

endmodule

>>> rtl/qcf_back.sv
// Back end: inverted index, posting walks, counters and match word sweep.
// Depends on qcf_pkg.
module qcf_back
    import qcf_pkg::*;
#(
    parameter int POSTINGS = POSTINGS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  cmd_t              q_cmd,
    output logic              pop,
    output logic              clearing,
    input  logic              cfg_valid,
    input  logic [7:0]        cfg_data,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [1:0]        status,
    output logic [WORD_W-1:0] word_index,
    output logic [63:0]       match_bits,
    output logic              last
);

    localparam int PW = $clog2(POSTINGS + 1);
    localparam int AW = $clog2(POSTINGS);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_LRES  = 11'b000_0000_0100,
        S_WTAB  = 11'b000_0000_1000,
        S_WPOST = 11'b000_0001_0000,
        S_WCNT  = 11'b000_0010_0000,
        S_WINC  = 11'b000_0100_0000,
        S_ERD   = 11'b000_1000_0000,
        S_ECHK  = 11'b001_0000_0000,
        S_EEMIT = 11'b010_0000_0000,
        S_SPARE = 11'b100_0000_0000
    } state_t;

    logic [PW-1:0]    tab_start_mem [GRAM_COUNT];
    logic [PW-1:0]    tab_len_mem   [GRAM_COUNT];
    logic [REC_W-1:0] post_mem      [POSTINGS];
    logic [7:0]       cnt_mem       [RECORDS];

    state_t state_reg, state_next;

    logic [7:0]        thr_reg;
    logic [REC_W-1:0]  clr_reg, clr_next;
    logic [PW-1:0]     fill_reg, fill_next;
    logic [GRAM_W-1:0] last_gram_reg, last_gram_next;
    logic [PW-1:0]     cur_start_reg, cur_start_next;
    logic [PW-1:0]     cur_len_reg, cur_len_next;
    logic [REC_W-1:0]  high_reg, high_next;
    logic [1:0]        res_st_reg, res_st_next;
    logic [PW-1:0]     wstart_reg, wstart_next;
    logic [PW-1:0]     wlen_reg, wlen_next;
    logic [PW-1:0]     k_reg, k_next;
    logic [REC_W-1:0]  rid_reg, rid_next;
    logic [WORD_W-1:0] w_reg, w_next;
    logic [BIT_W-1:0]  i_reg, i_next;
    logic [63:0]       bits_reg, bits_next;

    logic              tab_we, tab_re, post_we, post_re, cnt_we, cnt_re;
    logic [GRAM_W-1:0] tab_waddr, tab_raddr;
    logic [PW-1:0]     tab_wstart, tab_wlen, tab_start_rd_reg, tab_len_rd_reg;
    logic [AW-1:0]     post_waddr, post_raddr;
    logic [REC_W-1:0]  post_wdata, post_rd_reg;
    logic [REC_W-1:0]  cnt_waddr, cnt_raddr;
    logic [7:0]        cnt_wdata, cnt_rd_reg;
    logic [PW-1:0]     pos;
    logic [REC_W-1:0]  eid;

    logic              out_free, out_load;
    logic              out_valid_reg;
    logic [1:0]        status_reg, status_next;
    logic [WORD_W-1:0] word_index_reg, word_index_next;
    logic [63:0]       bits_out_reg, bits_out_next;
    logic              last_reg, last_next;

    assign clearing   = (state_reg == S_CLEAR);
    assign out_free   = ~out_valid_reg | ~out_stall;
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign word_index = word_index_reg;
    assign match_bits = bits_out_reg;
    assign last       = last_reg;
    assign pos        = wstart_reg + k_reg;
    assign eid        = {w_reg, i_reg};

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        fill_next       = fill_reg;
        last_gram_next  = last_gram_reg;
        cur_start_next  = cur_start_reg;
        cur_len_next    = cur_len_reg;
        high_next       = high_reg;
        res_st_next     = res_st_reg;
        wstart_next     = wstart_reg;
        wlen_next       = wlen_reg;
        k_next          = k_reg;
        rid_next        = rid_reg;
        w_next          = w_reg;
        i_next          = i_reg;
        bits_next       = bits_reg;
        pop             = 1'b0;
        tab_we          = 1'b0;
        tab_re          = 1'b0;
        tab_waddr       = clr_reg[GRAM_W-1:0];
        tab_raddr       = q_cmd.gram;
        tab_wstart      = '0;
        tab_wlen        = '0;
        post_we         = 1'b0;
        post_re         = 1'b0;
        post_waddr      = fill_reg[AW-1:0];
        post_raddr      = pos[AW-1:0];
        post_wdata      = q_cmd.rid;
        cnt_we          = 1'b0;
        cnt_re          = 1'b0;
        cnt_waddr       = clr_reg;
        cnt_raddr       = eid;
        cnt_wdata       = '0;
        out_load        = 1'b0;
        status_next     = ST_OK;
        word_index_next = '0;
        bits_out_next   = '0;
        last_next       = 1'b1;

        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_we = 1'b1;
                tab_we = (clr_reg < REC_W'(GRAM_COUNT));
                clr_next = clr_reg + 1'b1;
                if (clr_reg == REC_W'(RECORDS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    unique case (q_cmd.kind)
                        CMD_LOAD:
                        begin
                            state_next = S_LRES;
                            priority if (q_cmd.gram > GRAM_W'(GRAM_COUNT - 1) ||
                                         (fill_reg != '0 && q_cmd.gram < last_gram_reg))
                                res_st_next = ST_ORDER;
                            else if (fill_reg == PW'(POSTINGS))
                                res_st_next = ST_FULL;
                            else
                            begin
                                res_st_next = ST_OK;
                                if (fill_reg == '0 || q_cmd.gram != last_gram_reg)
                                begin
                                    cur_start_next = fill_reg;
                                    cur_len_next   = PW'(1);
                                end
                                else
                                    cur_len_next = cur_len_reg + 1'b1;
                                tab_we         = 1'b1;
                                tab_waddr      = q_cmd.gram;
                                tab_wstart     = cur_start_next;
                                tab_wlen       = cur_len_next;
                                post_we        = 1'b1;
                                fill_next      = fill_reg + 1'b1;
                                last_gram_next = q_cmd.gram;
                                if (q_cmd.rid > high_reg)
                                    high_next = q_cmd.rid;
                            end
                        end
                        CMD_WALK:
                        begin
                            tab_re     = 1'b1;
                            state_next = S_WTAB;
                        end
                        CMD_END:
                        begin
                            w_next     = '0;
                            i_next     = '0;
                            bits_next  = '0;
                            state_next = S_ERD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LRES:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    status_next = res_st_reg;
                    state_next  = S_IDLE;
                end
            end
            S_WTAB:
            begin
                wstart_next = tab_start_rd_reg;
                wlen_next   = tab_len_rd_reg;
                k_next      = '0;
                state_next  = (tab_len_rd_reg == '0) ? S_IDLE : S_WPOST;
            end
            S_WPOST:
            begin
                post_re    = 1'b1;
                state_next = S_WCNT;
            end
            S_WCNT:
            begin
                cnt_re     = 1'b1;
                cnt_raddr  = post_rd_reg;
                rid_next   = post_rd_reg;
                state_next = S_WINC;
            end
            S_WINC:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = rid_reg;
                cnt_wdata = (cnt_rd_reg == COUNT_MAX) ? COUNT_MAX : cnt_rd_reg + 8'd1;
                k_next    = k_reg + 1'b1;
                state_next = (k_next == wlen_reg) ? S_IDLE : S_WPOST;
            end
            S_ERD:
            begin
                cnt_re     = 1'b1;
                state_next = S_ECHK;
            end
            S_ECHK:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = eid;
                bits_next[i_reg] = (cnt_rd_reg >= thr_reg) && (eid <= high_reg);
                i_next     = i_reg + 1'b1;
                state_next = (i_reg == '1) ? S_EEMIT : S_ERD;
            end
            S_EEMIT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    word_index_next = w_reg;
                    bits_out_next   = bits_reg;
                    last_next       = (w_reg == high_reg[REC_W-1:BIT_W]);
                    bits_next       = '0;
                    w_next          = w_reg + 1'b1;
                    state_next      = last_next ? S_IDLE : S_ERD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_start_mem[tab_waddr] <= tab_wstart;
            tab_len_mem[tab_waddr]   <= tab_wlen;
        end
        if (tab_re)
        begin
            tab_start_rd_reg <= tab_start_mem[tab_raddr];
            tab_len_rd_reg   <= tab_len_mem[tab_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (post_we)
            post_mem[post_waddr] <= post_wdata;
        if (post_re)
            post_rd_reg <= post_mem[post_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        if (cnt_re)
            cnt_rd_reg <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        res_st_reg <= res_st_next;
        wstart_reg <= wstart_next;
        wlen_reg   <= wlen_next;
        k_reg      <= k_next;
        rid_reg    <= rid_next;
        bits_reg   <= bits_next;
        if (out_load)
        begin
            status_reg     <= status_next;
            word_index_reg <= word_index_next;
            bits_out_reg   <= bits_out_next;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            thr_reg       <= THRESH_RESET;
            fill_reg      <= '0;
            last_gram_reg <= '0;
            cur_start_reg <= '0;
            cur_len_reg   <= '0;
            high_reg      <= '0;
            w_reg         <= '0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            fill_reg      <= fill_next;
            last_gram_reg <= last_gram_next;
            cur_start_reg <= cur_start_next;
            cur_len_reg   <= cur_len_next;
            high_reg      <= high_next;
            w_reg         <= w_next;
            i_reg         <= i_next;
            if (cfg_valid)
                thr_reg <= cfg_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

>>> rtl/qgram_count_filter.sv
// Trigram count filter: loads an inverted index of grams to record ids, then
// counts shared grams per record over a query and reports match bit words.
// After reset a clearing pass over the counter memory and gram table runs before
// the first item is accepted. A load writes the index and then reports its status;
// a query character whose window holds no full gram pushes no command, else the
// gram's table entry is read and each entry of its posting list takes a posting
// read and a read-modify-write of the counter memory; end of query reads and clears
// each record counter in turn and emits one 64-record word at a time. A four-entry
// command queue lets the front keep accepting while the back works.
// Depends on qcf_pkg, qcf_front, qcf_queue and qcf_back.
module qgram_count_filter
    import qcf_pkg::*;
#(
    parameter int POSTINGS = POSTINGS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        mode,
    input  logic [GRAM_W-1:0] gram_code,
    input  logic [REC_W-1:0]  record_id,
    input  logic [7:0]        query_char,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        match_threshold,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [WORD_W-1:0] word_index,
    output logic [63:0]       match_bits,
    output logic              last
);

    logic push, pop, q_full, q_valid, clearing;
    cmd_t push_cmd, q_cmd;

    assign cfg_ready = 1'b1;

    qcf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .gram_code  (gram_code),
        .record_id  (record_id),
        .query_char (query_char),
        .q_full     (q_full),
        .clearing   (clearing),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    qcf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    qcf_back #(
        .POSTINGS (POSTINGS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .pop        (pop),
        .clearing   (clearing),
        .cfg_valid  (cfg_valid & cfg_ready),
        .cfg_data   (match_threshold),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .status     (status),
        .word_index (word_index),
        .match_bits (match_bits),
        .last       (last)
    );

endmodule

>>> rtl/qcf_checker.sv
// Port-level checks of the q-gram count filter, bound to the top level.
// Depends on qcf_pkg and qgram_count_filter.
module qcf_checker
    import qcf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [1:0]        status,
    input logic [WORD_W-1:0] word_index,
    input logic [63:0]       match_bits,
    input logic              last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last)
        else $error("rejected load not marked last");

    a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> match_bits == '0 && word_index == '0)
        else $error("rejected load carries match data");

    a_word_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && word_index != '0 |-> status == ST_OK)
        else $error("match word with error status");

endmodule

bind qgram_count_filter qcf_checker u_qcf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .word_index (word_index),
    .match_bits (match_bits),
    .last       (last)
);

>>> tb/qgram_count_filter_tb.sv
// Self-checking testbench for qgram_count_filter: loads gram posting lists, runs
// queries and checks every status and match word against an in-bench predictor.
// Depends on qcf_pkg and the qgram_count_filter RTL.
module qgram_count_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qcf_pkg::*;

    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam int         CYCLE_LIMIT  = 3000000;
    localparam int         SETTLE       = 300;

    typedef struct {
        logic [1:0]  status;
        logic [5:0]  widx;
        logic [63:0] bits;
        logic        last;
    } match_word_t;

    class match_scoreboard;
        logic [7:0]  threshold;
        logic [7:0]  win;
        int          win_fill;
        int          gram_start [GRAM_COUNT];
        int          gram_len [GRAM_COUNT];
        logic [11:0] postings [POSTINGS_DEF];
        int          counts [RECORDS];
        int          highest;
        int          last_gram;
        int          post_fill;
        int          errors;
        match_word_t pending_q [$];

        function new();
            threshold = THRESH_RESET;
            win = 0;
            win_fill = 0;
            foreach (gram_start[i]) gram_start[i] = 0;
            foreach (gram_len[i]) gram_len[i] = 0;
            foreach (counts[i]) counts[i] = 0;
            highest = 0;
            last_gram = 0;
            post_fill = 0;
            errors = 0;
        endfunction

        function void note_word(logic [1:0] md, logic [9:0] g, logic [11:0] r,
                                logic [7:0] c);
            match_word_t w;
            logic [3:0]  d;
            int          gi;
            int          pos;
            int          words;
            int          id;
            case (md)
                MODE_LOAD:
                begin
                    w.status = ST_OK;
                    if (g >= GRAM_COUNT)
                        w.status = ST_ORDER;
                    else if (post_fill > 0 && g < last_gram)
                        w.status = ST_ORDER;
                    else if (post_fill >= POSTINGS_DEF)
                        w.status = ST_FULL;
                    else
                    begin
                        if (post_fill == 0 || g != last_gram)
                        begin
                            gram_start[g] = post_fill;
                            gram_len[g] = 0;
                        end
                        postings[post_fill] = r;
                        gram_len[g]++;
                        post_fill++;
                        last_gram = g;
                        if (r > highest) highest = r;
                    end
                    w.widx = 0;
                    w.bits = 0;
                    w.last = 1;
                    pending_q.push_back(w);
                end
                MODE_QUERY:
                begin
                    d = (c >= CHAR_A && c <= CHAR_J) ? 4'(c - CHAR_A) : NOT_LETTER;
                    if (win_fill >= 2 && win[7:4] < LETTER_LIMIT &&
                        win[3:0] < LETTER_LIMIT && d < LETTER_LIMIT)
                    begin
                        gi = win[7:4] * 100 + win[3:0] * 10 + d;
                        for (int k = 0; k < gram_len[gi]; k++)
                        begin
                            pos = gram_start[gi] + k;
                            if (pos >= POSTINGS_DEF) break;
                            if (counts[postings[pos]] < COUNT_MAX)
                                counts[postings[pos]]++;
                        end
                    end
                    win = {win[3:0], d};
                    if (win_fill < 2) win_fill++;
                end
                MODE_END:
                begin
                    words = highest / 64 + 1;
                    if (words > 64) words = 64;
                    for (int wn = 0; wn < words; wn++)
                    begin
                        w.status = ST_OK;
                        w.widx = 6'(wn);
                        w.bits = 0;
                        for (int i = 0; i < 64; i++)
                        begin
                            id = wn * 64 + i;
                            if (id <= highest && counts[id] >= threshold)
                                w.bits[i] = 1'b1;
                        end
                        w.last = (wn + 1 == words);
                        pending_q.push_back(w);
                    end
                    foreach (counts[i]) counts[i] = 0;
                    win = 0;
                    win_fill = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic [1:0] st, logic [5:0] wi, logic [63:0] bits,
                                 logic lst);
            match_word_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected word status %0d index %0d bits %h last %0d",
                         $time, st, wi, bits, lst);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (st !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (wi !== e.widx)
            begin
                $display("%0t: word_index expected %0d actual %0d", $time, e.widx, wi);
                errors++;
            end
            if (bits !== e.bits)
            begin
                $display("%0t: match_bits expected %h actual %h", $time, e.bits, bits);
                errors++;
            end
            if (lst !== e.last)
            begin
                $display("%0t: last expected %0d actual %0d", $time, e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        mode;
    logic [GRAM_W-1:0] gram_code;
    logic [REC_W-1:0]  record_id;
    logic [7:0]        query_char;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [7:0]        match_threshold;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        status;
    logic [WORD_W-1:0] word_index;
    logic [63:0]       match_bits;
    logic              last;

    match_scoreboard sb = new();
    bit              valid_up = 0;
    bit              quiet = 0;
    int              hold_req = 0;
    int              cycles = 0;
    int              gram_list [$];
    int              gidx;

    qgram_count_filter i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .gram_code       (gram_code),
        .record_id       (record_id),
        .query_char      (query_char),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .match_threshold (match_threshold),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .word_index      (word_index),
        .match_bits      (match_bits),
        .last            (last)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_word(mode, gram_code, record_id, query_char);
            if (out_valid && !out_stall)
                sb.check_word(status, word_index, match_bits, last);
        end
    end

    always @(posedge clk)
    begin
        int r;
        if (hold_req > 0)
        begin
            out_stall <= 1'b1;
            hold_req--;
        end
        else if (quiet)
            out_stall <= 1'b0;
        else
        begin
            r = $urandom_range(0, 199);
            if (r == 0)
                hold_req = $urandom_range(20, 80);
            out_stall <= (r < 50);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70) return 0;
        if (r < 96) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_word(logic [1:0] md, logic [9:0] g, logic [11:0] r,
                             logic [7:0] c);
        int gap;
        in_valid <= 1'b1;
        mode <= md;
        gram_code <= g;
        record_id <= r;
        query_char <= c;
        do @(posedge clk); while (in_stall);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            valid_up = 0;
            repeat (gap) @(posedge clk);
        end
        else
            valid_up = 1;
    endtask

    task automatic send_load(int g, int r);
        send_word(MODE_LOAD, 10'(g), 12'(r), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_char(logic [7:0] c);
        send_word(MODE_QUERY, 10'($urandom_range(0, 1023)), 12'($urandom_range(0, 4095)), c);
    endtask

    task automatic send_end();
        send_word(MODE_END, 10'($urandom_range(0, 1023)), 12'($urandom_range(0, 4095)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        if (valid_up)
        begin
            in_valid <= 1'b0;
            valid_up = 0;
        end
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_threshold(logic [7:0] v);
        cfg_valid <= 1'b1;
        match_threshold <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.threshold = v;
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return CHAR_A + 8'($urandom_range(0, 3));
        if (r < 92) return CHAR_A + 8'($urandom_range(4, 9));
        return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        int r;
        int n;
        rst_n = 0;
        in_valid = 0;
        mode = MODE_LOAD;
        gram_code = 0;
        record_id = 0;
        query_char = 0;
        cfg_valid = 0;
        match_threshold = 0;
        out_stall = 0;
        for (int a = 0; a < 4; a++)
            for (int b = 0; b < 4; b++)
                for (int c = 0; c < 4; c++)
                    gram_list.push_back(a * 100 + b * 10 + c);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        write_threshold(8'd1);
        send_load(0, 0);
        send_load(0, 4095);
        send_load(0, 7);
        send_load(1023, 5);
        send_load(5, 2);
        send_load(3, 9);
        send_load(10, 3);
        send_word(MODE_IGNORED, 10'd1023, 12'd4095, 8'hFF);
        send_char(CHAR_A);
        send_char(CHAR_A);
        send_char(CHAR_A);
        send_char(CHAR_A);
        send_char(8'h00);
        send_char(CHAR_A);
        send_char(CHAR_A);
        send_char(CHAR_A + 8'd5);
        send_char(CHAR_J);
        send_char(CHAR_J);
        send_char(8'hFF);
        send_char(CHAR_A + 8'd1);
        send_char(CHAR_A);
        send_char(CHAR_A);
        send_end();
        drain();
        write_threshold(8'd0);
        send_char(CHAR_A);
        send_char(CHAR_A);
        send_char(CHAR_A);
        send_end();
        drain();

        gidx = 4;
        for (int round = 0; round < 6; round++)
        begin
            write_threshold(8'($urandom_range(0, 5)));
            quiet = (round == 4);
            if (round == 2) hold_req = 400;
            for (int k = 0; k < 12; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    if ($urandom_range(0, 1))
                        send_load($urandom_range(1000, 1023), $urandom_range(0, 4095));
                    else
                        send_load($urandom_range(0, gram_list[gidx] - 1),
                                  $urandom_range(0, 4095));
                end
                else
                begin
                    if (r >= 65 && gidx < gram_list.size() - 1)
                        gidx = gidx + $urandom_range(1, 2);
                    if (gidx > gram_list.size() - 1) gidx = gram_list.size() - 1;
                    send_load(gram_list[gidx], ($urandom_range(0, 3) == 0) ?
                              $urandom_range(0, 4095) : $urandom_range(0, 15));
                end
            end
            n = $urandom_range(10, 20);
            for (int k = 0; k < n; k++)
                send_char(pick_char());
            send_end();
            drain();
        end
        quiet = 0;

        write_threshold(8'd255);
        quiet = 1;
        for (int k = 0; k < 64; k++)
            send_load(999, 1);
        quiet = 0;
        send_load(999, 4095);
        send_load(500, 2);
        send_load(1023, 3);
        for (int k = 0; k < 6; k++)
            send_char(CHAR_J);
        send_char(CHAR_A);
        send_char(CHAR_A);
        send_char(CHAR_A);
        send_end();
        drain();

        if (sb.pending_q.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, sb.pending_q.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
rtl/qcf_pkg.sv
rtl/qcf_front.sv
rtl/qcf_queue.sv
rtl/qcf_back.sv
rtl/qgram_count_filter.sv
rtl/qcf_checker.sv
tb/qgram_count_filter_tb.sv
